// ===== design/rmvm_pkg.sv =====
package rmvm_pkg;

  localparam int NUM_FEATURES = 16;
  localparam int FIDX_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

  localparam int IDX_W  = 4;
  localparam int MEAN_W = 32;
  localparam int SQ_W   = 48;
  localparam int CNT_W  = 24;

  localparam int DIF_W  = MEAN_W + 1;
  localparam int OPB_W  = DIF_W;
  localparam int NUM_W  = 56;
  localparam int DEN_W  = CNT_W + 1;
  localparam int PROD_W = SQ_W + OPB_W;
  localparam int STEP_W = 6;

  localparam logic [SQ_W-1:0]  SQ_MAX  = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_MERGE  = 1'b1;

  localparam logic [STEP_W-1:0] STEPS_DIF  = STEP_W'(DIF_W);
  localparam logic [STEP_W-1:0] STEPS_CNT  = STEP_W'(CNT_W);
  localparam logic [STEP_W-1:0] STEPS_F    = STEP_W'(MEAN_W);
  localparam logic [STEP_W-1:0] STEPS_WIDE = STEP_W'(NUM_W);

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } arith_op_t;

  typedef struct packed {
    logic             start;
    arith_op_t        op;
    logic [STEP_W-1:0] steps;
  } unit_req_t;

  typedef struct packed {
    logic              en;
    logic [FIDX_W-1:0] idx;
    logic [MEAN_W-1:0] mean;
    logic [SQ_W-1:0]   sq;
    logic              cnt_en;
    logic [CNT_W-1:0]  cnt;
  } store_wr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_I_DIV,
    S_I_MUL,
    S_M_SQ,
    S_M_NN,
    S_M_F,
    S_M_TERM,
    S_M_W1,
    S_M_W2,
    S_M_MEAN,
    S_WRITE,
    S_OUT
  } st_t;

  function automatic logic [DIF_W-1:0] mag33(logic [DIF_W-1:0] v);
    return v[DIF_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== design/rmvm_if.sv =====
interface rmvm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [rmvm_pkg::IDX_W-1:0]    feature_index;
  logic signed [rmvm_pkg::MEAN_W-1:0] sample_value;
  logic signed [rmvm_pkg::MEAN_W-1:0] other_mean;
  logic [rmvm_pkg::SQ_W-1:0]     other_sum_sq;
  logic [rmvm_pkg::CNT_W-1:0]    other_count;
  logic                          last_element;

  modport source (
    output valid, func, feature_index, sample_value, other_mean, other_sum_sq,
    other_count, last_element,
    input ready
  );
  modport sink (
    input valid, func, feature_index, sample_value, other_mean, other_sum_sq,
    other_count, last_element,
    output ready
  );
endinterface

interface rmvm_out_if;
  logic                          valid;
  logic                          ready;
  logic [rmvm_pkg::IDX_W-1:0]    out_index;
  logic signed [rmvm_pkg::MEAN_W-1:0] new_mean;
  logic [rmvm_pkg::SQ_W-1:0]     new_sum_sq;
  logic [rmvm_pkg::CNT_W-1:0]    new_count;

  modport source (
    output valid, out_index, new_mean, new_sum_sq, new_count,
    input ready
  );
  modport sink (
    input valid, out_index, new_mean, new_sum_sq, new_count,
    output ready
  );
endinterface

// ===== design/rmvm_arith.sv =====
module rmvm_arith (
  input  logic                        clk,
  input  logic                        rst,
  input  rmvm_pkg::unit_req_t         req,
  input  logic [rmvm_pkg::NUM_W-1:0]  opa,
  input  logic [rmvm_pkg::OPB_W-1:0]  opb,
  output logic                        done,
  output logic [rmvm_pkg::PROD_W-1:0] prod,
  output logic [rmvm_pkg::NUM_W-1:0]  quot
);
  import rmvm_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] left;
  arith_op_t         op;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] mcand;
  logic [OPB_W-1:0]  mplier;
  logic [DEN_W:0]    rem;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  den;
  logic [DEN_W:0]    rs;
  logic              ge;

  // restoring division, one quotient bit per step
  assign rs = {rem[DEN_W-1:0], num[NUM_W-1]};
  assign ge = (rs >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        left <= req.steps;
      end else if (busy) begin
        left <= left - 1'b1;
        if (left == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op     <= req.op;
      acc    <= '0;
      mcand  <= PROD_W'(opa);
      mplier <= opb;
      rem    <= '0;
      num    <= opa;
      den    <= opb[DEN_W-1:0];
    end else if (busy) begin
      if (op == OP_MUL) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
      end else begin
        rem <= ge ? (rs - {1'b0, den}) : rs;
        num <= {num[NUM_W-2:0], ge};
      end
    end
  end

  assign prod = acc;
  assign quot = num;

endmodule

// ===== design/rmvm_store.sv =====
module rmvm_store (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rmvm_pkg::FIDX_W-1:0] rd_idx,
  input  rmvm_pkg::store_wr_t         wr,
  output logic [rmvm_pkg::MEAN_W-1:0] rd_mean,
  output logic [rmvm_pkg::SQ_W-1:0]   rd_sq,
  output logic [rmvm_pkg::CNT_W-1:0]  count
);
  import rmvm_pkg::*;

  logic [MEAN_W-1:0] means [NUM_FEATURES];
  logic [SQ_W-1:0]   sums  [NUM_FEATURES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FEATURES; i++) begin
        means[i] <= '0;
        sums[i]  <= '0;
      end
      count <= '0;
    end else begin
      if (wr.en) begin
        means[wr.idx] <= wr.mean;
        sums[wr.idx]  <= wr.sq;
      end
      if (wr.cnt_en) begin
        count <= wr.cnt;
      end
    end
  end

  assign rd_mean = means[rd_idx];
  assign rd_sq   = sums[rd_idx];

endmodule

// ===== design/running_mean_variance_merge.sv =====
// Per-feature running mean and sum of squared deviations with one shared sample
// count, fed one feature element per request. All arithmetic runs on a single
// bit-serial multiply/divide unit that retires one bit per cycle. An insert
// runs a 33-step divide and a 33-step multiply, and a merge runs five
// multiplies of 24 to 33 steps and two 56-step divides; a merge whose total
// count is zero skips the unit. A request is taken only while the sequencer is
// idle; the finished result sits in an output register, so the next request
// may enter while it waits to be taken.
module running_mean_variance_merge (
  input  logic        clk,
  input  logic        rst,
  rmvm_in_if.sink     item,
  rmvm_out_if.source  result
);
  import rmvm_pkg::*;

  st_t state, state_next;

  logic              it_func;
  logic [IDX_W-1:0]  it_idx;
  logic [MEAN_W-1:0] it_x;
  logic [MEAN_W-1:0] it_omean;
  logic [SQ_W-1:0]   it_osq;
  logic [CNT_W-1:0]  it_ocnt;
  logic              it_last;

  logic [MEAN_W-1:0] mean_r;
  logic [SQ_W-1:0]   sq_r;
  logic [DIF_W-1:0]  dif;
  logic [SQ_W-1:0]   qv;
  logic [NUM_W:0]    wacc;
  logic              wneg;
  logic [MEAN_W-1:0] new_mean_r;
  logic [SQ_W-1:0]   new_sq_r;

  logic              res_valid;
  logic [IDX_W-1:0]  res_idx;
  logic [MEAN_W-1:0] res_mean;
  logic [SQ_W-1:0]   res_sq;
  logic [CNT_W-1:0]  res_cnt;

  unit_req_t         u_req;
  logic [NUM_W-1:0]  u_opa;
  logic [OPB_W-1:0]  u_opb;
  logic              u_done;
  logic [PROD_W-1:0] u_prod;
  logic [NUM_W-1:0]  u_quot;

  store_wr_t         wr;
  logic [FIDX_W-1:0] fidx;
  logic [MEAN_W-1:0] rd_mean;
  logic [SQ_W-1:0]   rd_sq;
  logic [CNT_W-1:0]  cnt;

  logic              accept;
  logic              in_range;
  logic              res_free;
  logic [DEN_W-1:0]  tot;
  logic [MEAN_W-1:0] sel_val;
  logic [DIF_W-1:0]  ld_dif;
  logic [DIF_W-1:0]  qq;
  logic [DIF_W-1:0]  qs;
  logic [DIF_W-1:0]  nm_ext;
  logic [MEAN_W-1:0] nm_ins;
  logic [DIF_W-1:0]  r_ins;
  logic [PROD_W-16:0] sum_ins;
  logic [SQ_W-1:0]   sq_ins;
  logic [PROD_W-9:0] t_full;
  logic [SQ_W-1:0]   term;
  logic [SQ_W:0]     s1;
  logic [SQ_W-1:0]   s1_sat;
  logic [SQ_W:0]     s2;
  logic [SQ_W-1:0]   sq_mrg;
  logic [NUM_W:0]    w1s;
  logic [NUM_W:0]    w2s;
  logic [NUM_W:0]    ws;
  logic [NUM_W:0]    wmag;
  logic [MEAN_W-1:0] mq;
  logic [MEAN_W-1:0] nm_mrg;

  rmvm_arith u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (u_req),
    .opa  (u_opa),
    .opb  (u_opb),
    .done (u_done),
    .prod (u_prod),
    .quot (u_quot)
  );

  rmvm_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (fidx),
    .wr      (wr),
    .rd_mean (rd_mean),
    .rd_sq   (rd_sq),
    .count   (cnt)
  );

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign res_free   = !res_valid || result.ready;
  assign fidx       = FIDX_W'(it_idx);
  assign in_range   = (32'(it_idx) < 32'(NUM_FEATURES));
  assign tot        = {1'b0, cnt} + {1'b0, it_ocnt};

  // insert datapath
  assign sel_val = (it_func == FUNC_MERGE) ? it_omean : it_x;
  assign ld_dif  = {sel_val[MEAN_W-1], sel_val} - {rd_mean[MEAN_W-1], rd_mean};
  assign qq      = u_quot[DIF_W-1:0];
  assign qs      = dif[DIF_W-1] ? (~qq + 1'b1) : qq;
  assign nm_ext  = {mean_r[MEAN_W-1], mean_r} + qs;
  assign nm_ins  = nm_ext[MEAN_W-1:0];
  assign r_ins   = {it_x[MEAN_W-1], it_x} - {nm_ins[MEAN_W-1], nm_ins};
  assign sum_ins = {{(PROD_W-15-SQ_W){1'b0}}, sq_r} + {1'b0, u_prod[PROD_W-1:16]};
  assign sq_ins  = (|sum_ins[PROD_W-16:SQ_W]) ? SQ_MAX : sum_ins[SQ_W-1:0];

  // merge datapath
  assign t_full = u_prod[PROD_W-1:8];
  assign term   = (|t_full[PROD_W-9:SQ_W]) ? SQ_MAX : t_full[SQ_W-1:0];
  assign s1     = {1'b0, sq_r} + {1'b0, it_osq};
  assign s1_sat = s1[SQ_W] ? SQ_MAX : s1[SQ_W-1:0];
  assign s2     = {1'b0, s1_sat} + {1'b0, term};
  assign sq_mrg = s2[SQ_W] ? SQ_MAX : s2[SQ_W-1:0];
  assign w1s    = mean_r[MEAN_W-1] ? (~{1'b0, u_prod[NUM_W-1:0]} + 1'b1)
                                   : {1'b0, u_prod[NUM_W-1:0]};
  assign w2s    = it_omean[MEAN_W-1] ? (~{1'b0, u_prod[NUM_W-1:0]} + 1'b1)
                                     : {1'b0, u_prod[NUM_W-1:0]};
  assign ws     = wacc + w2s;
  assign wmag   = ws[NUM_W] ? (~ws + 1'b1) : ws;
  assign mq     = u_quot[MEAN_W-1:0];
  assign nm_mrg = wneg ? (~mq + 1'b1) : mq;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_LOAD;
      S_LOAD: begin
        if (!in_range) begin
          state_next = S_OUT;
        end else if (it_func == FUNC_INSERT) begin
          state_next = S_I_DIV;
        end else if (tot == '0) begin
          state_next = S_OUT;
        end else begin
          state_next = S_M_SQ;
        end
      end
      S_I_DIV:  if (u_done) state_next = S_I_MUL;
      S_I_MUL:  if (u_done) state_next = S_WRITE;
      S_M_SQ:   if (u_done) state_next = S_M_NN;
      S_M_NN:   if (u_done) state_next = S_M_F;
      S_M_F:    if (u_done) state_next = S_M_TERM;
      S_M_TERM: if (u_done) state_next = S_M_W1;
      S_M_W1:   if (u_done) state_next = S_M_W2;
      S_M_W2:   if (u_done) state_next = S_M_MEAN;
      S_M_MEAN: if (u_done) state_next = S_WRITE;
      S_WRITE:  state_next = S_OUT;
      S_OUT:    if (res_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    u_req  = '{start: 1'b0, op: OP_MUL, steps: '0};
    u_opa  = '0;
    u_opb  = '0;
    wr     = '0;
    wr.idx = fidx;
    wr.mean = new_mean_r;
    wr.sq   = new_sq_r;
    case (state)
      S_LOAD: begin
        if (in_range && it_func == FUNC_INSERT) begin
          u_req = '{start: 1'b1, op: OP_DIV, steps: STEPS_DIF};
          u_opa = {mag33(ld_dif), {(NUM_W-DIF_W){1'b0}}};
          u_opb = OPB_W'({1'b0, cnt} + 1'b1);
        end else if (in_range && tot != '0) begin
          u_req = '{start: 1'b1, op: OP_MUL, steps: STEPS_DIF};
          u_opa = NUM_W'(mag33(ld_dif));
          u_opb = mag33(ld_dif);
        end
      end
      S_I_DIV: begin
        if (u_done) begin
          u_req = '{start: 1'b1, op: OP_MUL, steps: STEPS_DIF};
          u_opa = NUM_W'(mag33(dif));
          u_opb = mag33(r_ins);
        end
      end
      S_M_SQ: begin
        if (u_done) begin
          u_req = '{start: 1'b1, op: OP_MUL, steps: STEPS_CNT};
          u_opa = NUM_W'(it_ocnt);
          u_opb = OPB_W'(cnt);
        end
      end
      S_M_NN: begin
        if (u_done) begin
          u_req = '{start: 1'b1, op: OP_DIV, steps: STEPS_WIDE};
          u_opa = {u_prod[NUM_W-9:0], 8'b0};
          u_opb = OPB_W'(tot);
        end
      end
      S_M_F: begin
        if (u_done) begin
          u_req = '{start: 1'b1, op: OP_MUL, steps: STEPS_F};
          u_opa = NUM_W'(qv);
          u_opb = OPB_W'(u_quot[MEAN_W-1:0]);
        end
      end
      S_M_TERM: begin
        if (u_done) begin
          u_req = '{start: 1'b1, op: OP_MUL, steps: STEPS_CNT};
          u_opa = NUM_W'(mag33({mean_r[MEAN_W-1], mean_r}));
          u_opb = OPB_W'(cnt);
        end
      end
      S_M_W1: begin
        if (u_done) begin
          u_req = '{start: 1'b1, op: OP_MUL, steps: STEPS_CNT};
          u_opa = NUM_W'(mag33({it_omean[MEAN_W-1], it_omean}));
          u_opb = OPB_W'(it_ocnt);
        end
      end
      S_M_W2: begin
        if (u_done) begin
          u_req = '{start: 1'b1, op: OP_DIV, steps: STEPS_WIDE};
          u_opa = wmag[NUM_W-1:0];
          u_opb = OPB_W'(tot);
        end
      end
      S_WRITE: begin
        wr.en     = 1'b1;
        wr.cnt_en = it_last;
        if (it_func == FUNC_INSERT) begin
          wr.cnt = (cnt == CNT_MAX) ? CNT_MAX : cnt + 1'b1;
        end else begin
          wr.cnt = tot[CNT_W] ? CNT_MAX : tot[CNT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && res_free) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_func  <= item.func;
      it_idx   <= item.feature_index;
      it_x     <= item.sample_value;
      it_omean <= item.other_mean;
      it_osq   <= item.other_sum_sq;
      it_ocnt  <= item.other_count;
      it_last  <= item.last_element;
    end
    case (state)
      S_LOAD: begin
        mean_r <= rd_mean;
        sq_r   <= rd_sq;
        dif    <= ld_dif;
        if (!in_range) begin
          new_mean_r <= '0;
          new_sq_r   <= '0;
        end else begin
          new_mean_r <= rd_mean;
          new_sq_r   <= rd_sq;
        end
      end
      S_I_DIV:  if (u_done) new_mean_r <= nm_ins;
      S_I_MUL:  if (u_done) new_sq_r <= sq_ins;
      S_M_SQ:   if (u_done) qv <= u_prod[SQ_W+15:16];
      S_M_TERM: if (u_done) new_sq_r <= sq_mrg;
      S_M_W1:   if (u_done) wacc <= w1s;
      S_M_W2:   if (u_done) wneg <= ws[NUM_W];
      S_M_MEAN: if (u_done) new_mean_r <= nm_mrg;
      S_OUT: begin
        if (res_free) begin
          res_idx  <= it_idx;
          res_mean <= new_mean_r;
          res_sq   <= new_sq_r;
          res_cnt  <= cnt;
        end
      end
      default: ;
    endcase
  end

  assign result.valid      = res_valid;
  assign result.out_index  = res_idx;
  assign result.new_mean   = res_mean;
  assign result.new_sum_sq = res_sq;
  assign result.new_count  = res_cnt;

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |=> (cnt >= $past(cnt)))
    else $error("sample count went down on commit");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    u_done |-> (state == S_I_DIV || state == S_I_MUL || state == S_M_SQ ||
                state == S_M_NN || state == S_M_F || state == S_M_TERM ||
                state == S_M_W1 || state == S_M_W2 || state == S_M_MEAN))
    else $error("unit finished outside a wait state");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && res_valid && !result.ready) |=> (state == S_OUT))
    else $error("result overwritten before it was taken");

  a_no_start_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_OUT || state == S_WRITE) |-> !u_req.start)
    else $error("unit started outside the sequence");

endmodule
